/* rtl/hsfd_pkg.sv */
// Shared types and constants for the header-synchronised frame deframer.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package hsfd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned JOINT_IDX_W = 4;
  localparam int unsigned HDR_LEN     = 4;
  localparam int unsigned HDR_CNT_W   = 2;

  // Frame header "_CMD", first byte at index zero.
  localparam logic [BYTE_W-1:0] HDR_BYTES [HDR_LEN] = '{8'h5F, 8'h43, 8'h4D, 8'h44};

  // Events from the header matcher to the rest of the block.
  typedef struct packed {
    logic wr_en;       // a payload byte is written this cycle
    logic frame_done;  // the final payload byte of a frame was taken
  } hunt_ev_t;

endpackage

`default_nettype wire

/* rtl/header_sync_frame_deframer.sv */
// Top level of the header-synchronised frame deframer: byte input, joint position output.
// Depends on hsfd_pkg, hsfd_hunt, hsfd_ram and hsfd_drain.
//
//  Channel  Direction  Handshake               Payload
//  ------   ---------  ----------------------  ------------------------------------------
//  in       input      in_valid_i / in_ready_o rx_byte_i
//  out      output     out_valid_o/out_ready_i joint_index_o, joint_position_o,
//                                              last_of_frame_o
//
// While hunting or receiving payload, one byte is taken every cycle.
// The byte that completes a frame starts a drain that steps through D_LO, D_HI and D_PUT for
// each joint, with two reads of the payload memory per joint; in_ready_o is low
// during the drain. A stalled output holds the drain in place until the item is taken.
// Reset returns the block to hunting; the payload memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module header_sync_frame_deframer #(
  parameter int unsigned PAYLOAD_BYTES = 22,
  parameter int unsigned NUM_JOINTS    = 9
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [hsfd_pkg::BYTE_W-1:0]        rx_byte_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [hsfd_pkg::JOINT_IDX_W-1:0]   joint_index_o,
  output logic signed [hsfd_pkg::POS_W-1:0]       joint_position_o,
  output logic                                    last_of_frame_o
);

  localparam int unsigned AW = $clog2(PAYLOAD_BYTES);

  hsfd_pkg::hunt_ev_t          ev;
  logic [AW-1:0]               wr_addr;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [hsfd_pkg::BYTE_W-1:0] rd_data;
  logic                        busy;
  logic                        accept;

  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;

  hsfd_hunt #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .AW            (AW)
  ) u_hunt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .ev_o      (ev),
    .wr_addr_o (wr_addr)
  );

  hsfd_ram #(
    .DEPTH (PAYLOAD_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ev.wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (rx_byte_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  hsfd_drain #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .NUM_JOINTS    (NUM_JOINTS),
    .AW            (AW)
  ) u_drain (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (ev.frame_done),
    .busy_o           (busy),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .joint_index_o    (joint_index_o),
    .joint_position_o (joint_position_o),
    .last_of_frame_o  (last_of_frame_o)
  );

  // Payload writes and drain reads never overlap, so no forwarding is needed.
  a_no_write_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !ev.wr_en)
    else $error("payload written while a frame drains");

  a_done_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev.frame_done |=> !in_ready_o)
    else $error("input not held off after frame end");

  a_read_only_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> busy)
    else $error("payload read outside a drain");

endmodule

`default_nettype wire

/* rtl/hsfd_ram.sv */
// Payload byte store: one write port, one read port with registered read data.
// Depends on hsfd_pkg for the byte width.
`timescale 1ns / 1ps
`default_nettype none

module hsfd_ram #(
  parameter int unsigned DEPTH = 22,
  parameter int unsigned AW    = 5
) (
  input  wire logic                           clk_i,
  input  wire logic                           wr_en_i,
  input  wire logic [AW-1:0]                  wr_addr_i,
  input  wire logic [hsfd_pkg::BYTE_W-1:0]    wr_data_i,
  input  wire logic                           rd_en_i,
  input  wire logic [AW-1:0]                  rd_addr_i,
  output logic      [hsfd_pkg::BYTE_W-1:0]    rd_data_o
);

  logic [hsfd_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [hsfd_pkg::BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* rtl/hsfd_hunt.sv */
// Header matcher and payload counter: hunts for "_CMD", then writes the payload bytes.
// Depends on hsfd_pkg for the header bytes and the event struct.
`timescale 1ns / 1ps
`default_nettype none

module hsfd_hunt #(
  parameter int unsigned PAYLOAD_BYTES = 22,
  parameter int unsigned AW            = 5
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [hsfd_pkg::BYTE_W-1:0] rx_byte_i,
  output hsfd_pkg::hunt_ev_t               ev_o,
  output logic      [AW-1:0]               wr_addr_o
);

  logic                           in_sync_q, in_sync_d;
  logic [hsfd_pkg::HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [AW-1:0]                  pay_cnt_q, pay_cnt_d;
  logic                           pay_last;

  assign pay_last = (pay_cnt_q == AW'(PAYLOAD_BYTES - 1));

  always_comb begin
    in_sync_d = in_sync_q;
    hdr_cnt_d = hdr_cnt_q;
    pay_cnt_d = pay_cnt_q;
    ev_o      = '0;
    if (accept_i) begin
      if (in_sync_q) begin
        ev_o.wr_en = 1'b1;
        if (pay_last) begin
          in_sync_d       = 1'b0;
          pay_cnt_d       = '0;
          ev_o.frame_done = 1'b1;
        end else begin
          pay_cnt_d = pay_cnt_q + AW'(1);
        end
      end else if (rx_byte_i == hsfd_pkg::HDR_BYTES[hdr_cnt_q]) begin
        if (hdr_cnt_q == hsfd_pkg::HDR_CNT_W'(hsfd_pkg::HDR_LEN - 1)) begin
          in_sync_d = 1'b1;
          hdr_cnt_d = '0;
          pay_cnt_d = '0;
        end else begin
          hdr_cnt_d = hdr_cnt_q + hsfd_pkg::HDR_CNT_W'(1);
        end
      end else if (rx_byte_i == hsfd_pkg::HDR_BYTES[0]) begin
        // A stray header start byte begins a fresh match.
        hdr_cnt_d = hsfd_pkg::HDR_CNT_W'(1);
      end else begin
        hdr_cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sync_q <= 1'b0;
      hdr_cnt_q <= '0;
      pay_cnt_q <= '0;
    end else begin
      in_sync_q <= in_sync_d;
      hdr_cnt_q <= hdr_cnt_d;
      pay_cnt_q <= pay_cnt_d;
    end
  end

  assign wr_addr_o = pay_cnt_q;

  // The header count is only meaningful while hunting.
  a_sync_hdr_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_sync_q |-> hdr_cnt_q == '0)
    else $error("header count not cleared while receiving payload");

  a_done_ends_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_o.frame_done |=> !in_sync_q && pay_cnt_q == '0)
    else $error("frame end did not return to hunting");

  a_wr_only_in_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_o.wr_en |-> in_sync_q)
    else $error("payload write while hunting");

endmodule

`default_nettype wire

/* rtl/hsfd_drain.sv */
// Frame drain: reads the stored payload two bytes per joint and presents joint positions.
// Depends on hsfd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module hsfd_drain #(
  parameter int unsigned PAYLOAD_BYTES = 22,
  parameter int unsigned NUM_JOINTS    = 9,
  parameter int unsigned AW            = 5
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  output logic                                    rd_en_o,
  output logic      [AW-1:0]                      rd_addr_o,
  input  wire logic [hsfd_pkg::BYTE_W-1:0]        rd_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [hsfd_pkg::JOINT_IDX_W-1:0]   joint_index_o,
  output logic signed [hsfd_pkg::POS_W-1:0]       joint_position_o,
  output logic                                    last_of_frame_o
);

  localparam int unsigned JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int unsigned XW = $clog2(2 * NUM_JOINTS + PAYLOAD_BYTES + 1);

  typedef enum logic [1:0] {
    D_IDLE,
    D_LO,
    D_HI,
    D_PUT
  } drain_state_e;

  drain_state_e                       state_q;
  logic [JW-1:0]                      jnt_q;
  logic                               zero_q;
  logic [hsfd_pkg::BYTE_W-1:0]        lo_q;
  logic                               out_valid_q;
  logic [hsfd_pkg::JOINT_IDX_W-1:0]   idx_q;
  logic signed [hsfd_pkg::POS_W-1:0]  pos_q;
  logic                               last_q;

  logic [XW-1:0]               byte_idx;
  logic                        in_range;
  logic                        jnt_last;
  logic                        put;
  logic [hsfd_pkg::BYTE_W-1:0] hi_byte;

  // Joint k uses bytes 2k and 2k+1; bytes past the store read as zero.
  assign byte_idx  = {(XW - 1)'(jnt_q), (state_q == D_HI)};
  assign in_range  = (byte_idx < XW'(PAYLOAD_BYTES));
  assign rd_en_o   = ((state_q == D_LO) || (state_q == D_HI)) && in_range;
  assign rd_addr_o = byte_idx[AW-1:0];
  assign jnt_last  = (jnt_q == JW'(NUM_JOINTS - 1));
  assign put       = (state_q == D_PUT) && (!out_valid_q || out_ready_i);
  assign hi_byte   = zero_q ? '0 : rd_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= D_IDLE;
      jnt_q       <= '0;
      zero_q      <= 1'b0;
      lo_q        <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      pos_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_ready_i && !put) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            jnt_q   <= '0;
            state_q <= D_LO;
          end
        end
        D_LO: begin
          zero_q  <= !in_range;
          state_q <= D_HI;
        end
        D_HI: begin
          lo_q    <= zero_q ? '0 : rd_data_i;
          zero_q  <= !in_range;
          state_q <= D_PUT;
        end
        D_PUT: begin
          if (put) begin
            out_valid_q <= 1'b1;
            idx_q       <= hsfd_pkg::JOINT_IDX_W'(jnt_q);
            pos_q       <= {hi_byte, lo_q};
            last_q      <= jnt_last;
            if (jnt_last) begin
              state_q <= D_IDLE;
            end else begin
              jnt_q   <= jnt_q + JW'(1);
              state_q <= D_LO;
            end
          end
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
    end
  end

  assign busy_o           = (state_q != D_IDLE);
  assign out_valid_o      = out_valid_q;
  assign joint_index_o    = idx_q;
  assign joint_position_o = pos_q;
  assign last_of_frame_o  = last_q;

  a_last_is_final_joint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> last_q == (idx_q == hsfd_pkg::JOINT_IDX_W'(NUM_JOINTS - 1)))
    else $error("last flag disagrees with joint index");

  a_start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == D_IDLE)
    else $error("frame completed while previous frame still draining");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o)
    else $error("drain did not start after frame end");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for header_sync_frame_deframer: sends byte streams of headers, noise
// and frames, predicts every joint position and checks each output item as it is taken.
// Depends on hsfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned PAYLOAD_BYTES = 22;
  localparam int unsigned NUM_JOINTS    = 9;
  localparam int unsigned TOTAL_BYTES   = 260;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned TAIL_CYCLES   = 40;

  typedef struct packed {
    logic [hsfd_pkg::JOINT_IDX_W-1:0] idx;
    logic [hsfd_pkg::POS_W-1:0]       pos;
    logic                             last;
  } joint_pos_t;

  typedef struct packed {
    logic [hsfd_pkg::BYTE_W-1:0] b;
    logic                        drain_first;
  } tx_byte_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_stall_e;

  logic                                    clk            = 1'b0;
  logic                                    rst_n          = 1'b0;
  logic                                    in_valid       = 1'b0;
  logic                                    in_ready;
  logic        [hsfd_pkg::BYTE_W-1:0]      rx_byte        = '0;
  logic                                    out_valid;
  logic                                    out_ready      = 1'b0;
  logic        [hsfd_pkg::JOINT_IDX_W-1:0] joint_index;
  logic signed [hsfd_pkg::POS_W-1:0]       joint_position;
  logic                                    last_of_frame;

  header_sync_frame_deframer #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .NUM_JOINTS    (NUM_JOINTS)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .joint_index_o    (joint_index),
    .joint_position_o (joint_position),
    .last_of_frame_o  (last_of_frame)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicted deframer state.
  logic                        frm_in_sync = 1'b0;
  int unsigned                 hdr_seen    = 0;
  int unsigned                 frm_count   = 0;
  logic [hsfd_pkg::BYTE_W-1:0] frm_store [PAYLOAD_BYTES];

  tx_byte_t    bytes_to_send [$];
  joint_pos_t  joints_due [$];
  int unsigned errors          = 0;
  int unsigned bytes_taken     = 0;
  int unsigned frames_done     = 0;
  int unsigned joints_checked  = 0;
  int unsigned hdr_restarts    = 0;
  int unsigned cycles          = 0;

  task automatic deframe_byte(input logic [hsfd_pkg::BYTE_W-1:0] b);
    joint_pos_t jp;
    if (frm_in_sync) begin
      frm_store[frm_count] = b;
      frm_count++;
      if (frm_count == PAYLOAD_BYTES) begin
        frm_in_sync = 1'b0;
        frm_count   = 0;
        hdr_seen    = 0;
        for (int k = 0; k < NUM_JOINTS; k++) begin
          jp.idx  = hsfd_pkg::JOINT_IDX_W'(k);
          jp.pos  = {frm_store[2*k+1], frm_store[2*k]};
          jp.last = (k == NUM_JOINTS - 1);
          joints_due.insert(joints_due.size(), jp);
        end
        frames_done++;
      end
    end else if (hdr_seen < hsfd_pkg::HDR_LEN && b == hsfd_pkg::HDR_BYTES[hdr_seen]) begin
      hdr_seen++;
      if (hdr_seen == hsfd_pkg::HDR_LEN) begin
        frm_in_sync = 1'b1;
        frm_count   = 0;
      end
    end else if (b == hsfd_pkg::HDR_BYTES[0]) begin
      if (hdr_seen != 0) hdr_restarts++;
      hdr_seen = 1;
    end else begin
      hdr_seen = 0;
    end
  endtask

  task automatic queue_byte(input logic [hsfd_pkg::BYTE_W-1:0] b,
                            input logic drain_first = 1'b0);
    tx_byte_t t;
    t.b           = b;
    t.drain_first = drain_first;
    bytes_to_send.insert(bytes_to_send.size(), t);
  endtask

  task automatic queue_header(input logic drain_first = 1'b0);
    queue_byte(hsfd_pkg::HDR_BYTES[0], drain_first);
    for (int i = 1; i < hsfd_pkg::HDR_LEN; i++) queue_byte(hsfd_pkg::HDR_BYTES[i]);
  endtask

  // Sender: bursts of items separated by random gaps. An item flagged drain_first is held
  // back until every predicted joint position has been taken.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    logic                        v_next;
    logic [hsfd_pkg::BYTE_W-1:0] b_next;
    tx_byte_t                    t;
    if (rst_n) begin
      v_next = in_valid;
      b_next = rx_byte;
      if (in_valid && in_ready) begin
        deframe_byte(rx_byte);
        bytes_taken++;
        v_next = 1'b0;
      end
      if (!v_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (bytes_to_send.size() > 0 &&
                     (!bytes_to_send[0].drain_first || joints_due.size() == 0)) begin
          t      = bytes_to_send.pop_front();
          v_next = 1'b1;
          b_next = t.b;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_valid <= v_next;
      rx_byte  <= b_next;
    end
  end

  // Receiver: drives out_ready from a stall pattern that is redrawn at random from four modes.
  rx_stall_e   stall_mode  = RX_ALWAYS;
  int unsigned stall_phase = 0;

  always @(posedge clk) begin
    joint_pos_t want;
    logic       r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (joints_due.size() == 0) begin
          $error("unexpected item: joint_index %0d joint_position %0d last_of_frame %0b",
                 joint_index, joint_position, last_of_frame);
          errors++;
        end else begin
          want = joints_due.pop_front();
          if (joint_index !== want.idx) begin
            $error("joint_index: expected %0d, got %0d", want.idx, joint_index);
            errors++;
          end
          if (joint_position !== want.pos) begin
            $error("joint_position: expected %0d, got %0d",
                   $signed(want.pos), joint_position);
            errors++;
          end
          if (last_of_frame !== want.last) begin
            $error("last_of_frame: expected %0b, got %0b", want.last, last_of_frame);
            errors++;
          end
          joints_checked++;
        end
      end
      stall_phase++;
      if (stall_phase % 64 == 0) stall_mode = rx_stall_e'($urandom_range(0, 3));
      case (stall_mode)
        RX_ALWAYS:   r = 1'b1;
        RX_COIN:     r = 1'($urandom_range(0, 1));
        RX_PERIODIC: r = (stall_phase % 5) < 2;
        default:     r = ($urandom_range(0, 7) == 0);
      endcase
      out_ready <= r;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d joint positions outstanding",
               cycles, joints_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned n;
    logic [hsfd_pkg::BYTE_W-1:0] extremes [22];
    extremes = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00,
                 8'h5F, 8'h43, 8'h4D, 8'h44, 8'h01, 8'h00, 8'h00, 8'h01,
                 8'hAA, 8'h55, 8'h5F, 8'h43, 8'h4D, 8'h44};

    // A mismatch to zero, a repeated underscore that restarts at one, then a frame whose
    // positions sit at the signed extremes and whose payload carries header bytes.
    queue_byte(hsfd_pkg::HDR_BYTES[0]);
    queue_byte(hsfd_pkg::HDR_BYTES[1]);
    queue_byte(8'h58);
    queue_byte(hsfd_pkg::HDR_BYTES[0]);
    queue_header();
    foreach (extremes[i]) queue_byte(extremes[i]);

    // The first random frame waits for the directed one to drain completely.
    queue_header(1'b1);
    repeat (PAYLOAD_BYTES) queue_byte(hsfd_pkg::BYTE_W'($urandom_range(0, 255)));

    while (bytes_to_send.size() < TOTAL_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        repeat ($urandom_range(0, 2)) queue_byte(hsfd_pkg::BYTE_W'($urandom_range(0, 255)));
        queue_header($urandom_range(0, 7) == 0);
        repeat (PAYLOAD_BYTES) queue_byte(hsfd_pkg::BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 8) begin
        // Partial header broken by an underscore or by a random byte.
        n = $urandom_range(1, hsfd_pkg::HDR_LEN - 1);
        for (int i = 0; i < n; i++) queue_byte(hsfd_pkg::HDR_BYTES[i]);
        queue_byte($urandom_range(0, 1) ? hsfd_pkg::HDR_BYTES[0]
                                        : hsfd_pkg::BYTE_W'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) queue_byte(hsfd_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (bytes_to_send.size() != 0 || in_valid) @(posedge clk);
    while (joints_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d bytes sent, %0d frames deframed, %0d joint positions checked,",
             bytes_taken, frames_done, joints_checked);
    $display("%0d header restarts on underscore, under bursty input and varied output stalls",
             hdr_restarts);
    if (errors == 0 && joints_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
